>>> src/btsd_pkg.sv
// ---------------------------------------------------------------------------
// btsd_pkg
// Shared types, constants and helpers for the byte translate/squeeze/delete
// unit.
// ---------------------------------------------------------------------------
package btsd_pkg;

  localparam int ALPHABET   = 256;
  localparam int LIST_DEPTH = 256;

  localparam int AW = $clog2(ALPHABET);
  localparam int LW = $clog2(LIST_DEPTH);
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int IW = ((AW + 1) > CW) ? (AW + 1) : CW;

  localparam int CODE_W  = 11;
  localparam int BIT_HIT = 8;
  localparam int BIT_DEL = 9;
  localparam int BIT_SQZ = 10;

  localparam logic [8:0] ALPHA_LIM = 9'(ALPHABET);

  typedef enum logic [2:0] {
    CMD_BEGIN = 3'd0,
    CMD_SET1  = 3'd1,
    CMD_END1  = 3'd2,
    CMD_SET2  = 3'd3,
    CMD_END2  = 3'd4,
    CMD_DATA  = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_DELETE  = 2'd0,
    CFG_SQUEEZE = 2'd1,
    CFG_COMPL   = 2'd2,
    CFG_TRUNC   = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_SET1 = 2'd0,
    PH_SET2 = 2'd1,
    PH_DATA = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    WK_CMP  = 2'd0,
    WK_DEL  = 2'd1,
    WK_FILL = 2'd2
  } walk_e;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       list_overflow;
  } out_item_t;

  typedef struct packed {
    logic delete_mode;
    logic squeeze_mode;
    logic complement_mode;
    logic truncate_mode;
  } cfg_t;

  typedef struct packed {
    logic  clear;
    logic  set1_wr;
    logic  s2_read;
    logic  s2_write;
    logic  lk_read;
    logic  lk_emit;
    logic  walk_init;
    walk_e kind;
    logic  walk_run;
    logic  end_s1;
    logic  end_s2;
  } ctl_cmd_t;

  typedef struct packed {
    phase_e phase;
    logic   walk_done;
    logic   lk_drop;
    logic   out_free;
  } dp_stat_t;

  function automatic logic [CODE_W-1:0] mk_code(input logic sq, input logic dl,
                                                input logic ht, input logic [7:0] v);
    return {sq, dl, ht, v};
  endfunction

endpackage

>>> src/btsd_ram.sv
// ---------------------------------------------------------------------------
// btsd_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module btsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> src/btsd_dpath.sv
// ---------------------------------------------------------------------------
// btsd_dpath
// Code table, source list, counters, table walks and output register.
// ---------------------------------------------------------------------------
module btsd_dpath (
  input  logic                clk,
  input  logic                rst_n,
  input  btsd_pkg::cfg_t      cfg,
  input  btsd_pkg::ctl_cmd_t  cmd,
  input  btsd_pkg::in_item_t  in_data,
  output btsd_pkg::dp_stat_t  stat,
  output logic                out_valid,
  input  logic                out_ready,
  output btsd_pkg::out_item_t out_data
);

  logic [btsd_pkg::CW-1:0]       count_r, count_nxt, pair_r, pair_nxt;
  btsd_pkg::phase_e              phase_r, phase_nxt;
  logic [7:0]                    last_s2_r, last_s2_nxt, val_r, val_nxt;
  logic [btsd_pkg::CODE_W-1:0]   last_code_r, last_code_nxt;
  logic                          last_vld_r, last_vld_nxt, ovf_r, ovf_nxt;
  logic [btsd_pkg::ALPHABET-1:0] tvld_r, tvld_nxt;
  logic                          rvld_r, rvld_nxt, inr_r, inr_nxt, s2_ok_r, s2_ok_nxt;
  logic [btsd_pkg::IW-1:0]       idx_r, idx_nxt, end_r, end_nxt, pidx_r, pidx_nxt;
  logic                          pend_r, pend_nxt;
  btsd_pkg::walk_e               kind_r, kind_nxt;
  btsd_pkg::out_item_t           out_r, out_nxt;
  logic                          out_valid_r, out_valid_nxt;

  logic                          t_we, t_re;
  logic [btsd_pkg::AW-1:0]       t_waddr, t_raddr;
  logic [btsd_pkg::CODE_W-1:0]   t_wdata, t_rdata;
  logic                          s_we, s_re;
  logic [btsd_pkg::LW-1:0]       s_waddr, s_raddr;
  logic [7:0]                    s_wdata, s_rdata;

  logic                          in_inr, c_inr, issue, t_hit, list_room, lk_drop;
  logic [btsd_pkg::CODE_W-1:0]   code_lk;
  logic [7:0]                    fill_v;

  btsd_ram #(.WIDTH(btsd_pkg::CODE_W), .DEPTH(btsd_pkg::ALPHABET)) u_code_ram (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .re    (t_re),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  btsd_ram #(.WIDTH(8), .DEPTH(btsd_pkg::LIST_DEPTH)) u_src_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .re    (s_re),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  assign in_inr    = {1'b0, in_data.value} < btsd_pkg::ALPHA_LIM;
  assign c_inr     = {1'b0, s_rdata} < btsd_pkg::ALPHA_LIM;
  assign issue     = idx_r < end_r;
  assign t_hit     = rvld_r & t_rdata[btsd_pkg::BIT_HIT];
  assign list_room = count_r < btsd_pkg::CW'(btsd_pkg::LIST_DEPTH);
  // entries never written read as identity
  assign code_lk   = (inr_r && rvld_r) ? t_rdata : btsd_pkg::mk_code(1'b0, 1'b0, 1'b0, val_r);
  assign lk_drop   = code_lk[btsd_pkg::BIT_DEL] || (last_vld_r && (code_lk == last_code_r));
  assign fill_v    = (pair_r != '0) ? (cfg.truncate_mode ? s_rdata : last_s2_r)
                                    : (cfg.squeeze_mode ? s_rdata : 8'd0);

  always_comb begin
    count_nxt     = count_r;
    pair_nxt      = pair_r;
    phase_nxt     = phase_r;
    last_s2_nxt   = last_s2_r;
    val_nxt       = val_r;
    last_code_nxt = last_code_r;
    last_vld_nxt  = last_vld_r;
    ovf_nxt       = ovf_r;
    tvld_nxt      = tvld_r;
    rvld_nxt      = rvld_r;
    inr_nxt       = inr_r;
    s2_ok_nxt     = s2_ok_r;
    idx_nxt       = idx_r;
    end_nxt       = end_r;
    pidx_nxt      = pidx_r;
    pend_nxt      = pend_r;
    kind_nxt      = kind_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    t_we          = 1'b0;
    t_waddr       = in_data.value[btsd_pkg::AW-1:0];
    t_wdata       = '0;
    t_re          = 1'b0;
    t_raddr       = in_data.value[btsd_pkg::AW-1:0];
    s_we          = 1'b0;
    s_waddr       = count_r[btsd_pkg::LW-1:0];
    s_wdata       = in_data.value;
    s_re          = 1'b0;
    s_raddr       = pair_r[btsd_pkg::LW-1:0];

    if (cmd.clear) begin
      tvld_nxt      = '0;
      count_nxt     = '0;
      pair_nxt      = '0;
      last_s2_nxt   = '0;
      last_code_nxt = '0;
      last_vld_nxt  = 1'b0;
      ovf_nxt       = 1'b0;
      phase_nxt     = btsd_pkg::PH_SET1;
    end

    if (cmd.set1_wr && in_inr) begin
      t_we    = 1'b1;
      t_waddr = in_data.value[btsd_pkg::AW-1:0];
      t_wdata = btsd_pkg::mk_code(1'b0, 1'b0, 1'b1, in_data.value);
      tvld_nxt[in_data.value[btsd_pkg::AW-1:0]] = 1'b1;
      if (list_room) begin
        s_we      = 1'b1;
        s_waddr   = count_r[btsd_pkg::LW-1:0];
        s_wdata   = in_data.value;
        count_nxt = count_r + btsd_pkg::CW'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end

    if (cmd.s2_read) begin
      val_nxt = in_data.value;
      inr_nxt = in_inr;
      if (cfg.delete_mode) begin
        t_re     = 1'b1;
        t_raddr  = in_data.value[btsd_pkg::AW-1:0];
        rvld_nxt = tvld_r[in_data.value[btsd_pkg::AW-1:0]];
      end else begin
        last_s2_nxt = in_data.value;
        s2_ok_nxt   = pair_r < count_r;
        s_re        = pair_r < count_r;
        s_raddr     = pair_r[btsd_pkg::LW-1:0];
      end
    end

    if (cmd.s2_write) begin
      if (cfg.delete_mode) begin
        if (cfg.squeeze_mode && inr_r && !(rvld_r && t_rdata[btsd_pkg::BIT_DEL])) begin
          t_we    = 1'b1;
          t_waddr = val_r[btsd_pkg::AW-1:0];
          t_wdata = btsd_pkg::mk_code(1'b1, 1'b0, 1'b0, val_r);
          tvld_nxt[val_r[btsd_pkg::AW-1:0]] = 1'b1;
        end
      end else if (s2_ok_r) begin
        pair_nxt = pair_r + btsd_pkg::CW'(1);
        if (c_inr) begin
          t_we    = 1'b1;
          t_waddr = s_rdata[btsd_pkg::AW-1:0];
          t_wdata = btsd_pkg::mk_code(cfg.squeeze_mode, 1'b0, 1'b0, val_r);
          tvld_nxt[s_rdata[btsd_pkg::AW-1:0]] = 1'b1;
        end
      end
    end

    if (cmd.lk_read) begin
      val_nxt  = in_data.value;
      inr_nxt  = in_inr;
      t_re     = 1'b1;
      t_raddr  = in_data.value[btsd_pkg::AW-1:0];
      rvld_nxt = tvld_r[in_data.value[btsd_pkg::AW-1:0]];
    end

    if (cmd.lk_emit) begin
      out_nxt.out_byte      = code_lk[7:0];
      out_nxt.list_overflow = ovf_r;
      out_valid_nxt         = 1'b1;
      last_code_nxt         = code_lk;
      last_code_nxt[btsd_pkg::BIT_SQZ] = 1'b1;
      last_vld_nxt          = 1'b1;
    end

    if (cmd.walk_run) begin
      pend_nxt = issue;
      pidx_nxt = idx_r;
      if (issue) begin
        idx_nxt = idx_r + btsd_pkg::IW'(1);
        unique case (kind_r)
          btsd_pkg::WK_CMP: begin
            t_re     = 1'b1;
            t_raddr  = idx_r[btsd_pkg::AW-1:0];
            rvld_nxt = tvld_r[idx_r[btsd_pkg::AW-1:0]];
          end
          btsd_pkg::WK_DEL, btsd_pkg::WK_FILL: begin
            s_re    = 1'b1;
            s_raddr = idx_r[btsd_pkg::LW-1:0];
          end
          default: ;
        endcase
      end
      if (pend_r) begin
        unique case (kind_r)
          btsd_pkg::WK_CMP: begin
            if (!t_hit) begin
              if (list_room) begin
                s_we      = 1'b1;
                s_waddr   = count_r[btsd_pkg::LW-1:0];
                s_wdata   = 8'(pidx_r);
                count_nxt = count_r + btsd_pkg::CW'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
          end
          btsd_pkg::WK_DEL: begin
            if (c_inr) begin
              // complement entries were never hit, plain set1 entries were
              t_we    = 1'b1;
              t_waddr = s_rdata[btsd_pkg::AW-1:0];
              t_wdata = btsd_pkg::mk_code(1'b0, 1'b1, ~cfg.complement_mode, s_rdata);
              tvld_nxt[s_rdata[btsd_pkg::AW-1:0]] = 1'b1;
            end
          end
          btsd_pkg::WK_FILL: begin
            if (c_inr) begin
              t_we    = 1'b1;
              t_waddr = s_rdata[btsd_pkg::AW-1:0];
              t_wdata = btsd_pkg::mk_code(cfg.squeeze_mode, 1'b0, 1'b0, fill_v);
              tvld_nxt[s_rdata[btsd_pkg::AW-1:0]] = 1'b1;
            end
          end
          default: ;
        endcase
      end
    end

    if (cmd.walk_init) begin
      kind_nxt = cmd.kind;
      pend_nxt = 1'b0;
      idx_nxt  = (cmd.kind == btsd_pkg::WK_FILL) ? btsd_pkg::IW'(pair_r) : '0;
      end_nxt  = (cmd.kind == btsd_pkg::WK_CMP) ? btsd_pkg::IW'(btsd_pkg::ALPHABET)
                                                 : btsd_pkg::IW'(count_r);
      if (cmd.kind == btsd_pkg::WK_CMP) begin
        count_nxt = '0;
      end
    end

    if (cmd.end_s1) begin
      pair_nxt  = '0;
      phase_nxt = btsd_pkg::PH_SET2;
    end

    if (cmd.end_s2) begin
      if (!cfg.delete_mode) begin
        pair_nxt = count_r;
      end
      phase_nxt = btsd_pkg::PH_DATA;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pair_r      <= '0;
      phase_r     <= btsd_pkg::PH_SET1;
      last_s2_r   <= '0;
      last_code_r <= '0;
      last_vld_r  <= 1'b0;
      ovf_r       <= 1'b0;
      tvld_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      pair_r      <= pair_nxt;
      phase_r     <= phase_nxt;
      last_s2_r   <= last_s2_nxt;
      last_code_r <= last_code_nxt;
      last_vld_r  <= last_vld_nxt;
      ovf_r       <= ovf_nxt;
      tvld_r      <= tvld_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r   <= val_nxt;
    rvld_r  <= rvld_nxt;
    inr_r   <= inr_nxt;
    s2_ok_r <= s2_ok_nxt;
    idx_r   <= idx_nxt;
    end_r   <= end_nxt;
    pidx_r  <= pidx_nxt;
    kind_r  <= kind_nxt;
    out_r   <= out_nxt;
  end

  assign stat.phase     = phase_r;
  assign stat.walk_done = !issue && !pend_r;
  assign stat.lk_drop   = lk_drop;
  assign stat.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_pend_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> cmd.walk_run)
    else $error("walk read pending outside a walk");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= btsd_pkg::CW'(btsd_pkg::LIST_DEPTH))
    else $error("source count beyond list depth");

  a_pair_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pair_r <= count_r)
    else $error("pair index beyond source count");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.lk_emit |-> (!out_valid_r || out_ready))
    else $error("word loaded over an untaken word");

  a_last_code: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> last_vld_r)
    else $error("word sent without squeeze history");

endmodule

>>> src/btsd_ctrl.sv
// ---------------------------------------------------------------------------
// btsd_ctrl
// Command sequencer: decodes input words and steps the table walks.
// ---------------------------------------------------------------------------
module btsd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  btsd_pkg::cfg_t     cfg,
  input  logic               in_valid,
  input  logic [2:0]         in_cmd,
  output logic               in_ready,
  input  btsd_pkg::dp_stat_t stat,
  output btsd_pkg::ctl_cmd_t cmd
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_LOOK  = 6'b000010,
    ST_S2    = 6'b000100,
    ST_WCMP  = 6'b001000,
    ST_WDEL  = 6'b010000,
    ST_WFILL = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_cmd)
            btsd_pkg::CMD_BEGIN: begin
              cmd.clear = 1'b1;
            end
            btsd_pkg::CMD_SET1: begin
              cmd.set1_wr = (stat.phase == btsd_pkg::PH_SET1);
            end
            btsd_pkg::CMD_END1: begin
              if (stat.phase == btsd_pkg::PH_SET1) begin
                if (cfg.complement_mode) begin
                  cmd.walk_init = 1'b1;
                  cmd.kind      = btsd_pkg::WK_CMP;
                  state_nxt     = ST_WCMP;
                end else if (cfg.delete_mode) begin
                  cmd.walk_init = 1'b1;
                  cmd.kind      = btsd_pkg::WK_DEL;
                  state_nxt     = ST_WDEL;
                end else begin
                  cmd.end_s1 = 1'b1;
                end
              end
            end
            btsd_pkg::CMD_SET2: begin
              if (stat.phase == btsd_pkg::PH_SET2) begin
                cmd.s2_read = 1'b1;
                state_nxt   = ST_S2;
              end
            end
            btsd_pkg::CMD_END2: begin
              if (stat.phase == btsd_pkg::PH_SET2) begin
                if (!cfg.delete_mode) begin
                  cmd.walk_init = 1'b1;
                  cmd.kind      = btsd_pkg::WK_FILL;
                  state_nxt     = ST_WFILL;
                end else begin
                  cmd.end_s2 = 1'b1;
                end
              end
            end
            btsd_pkg::CMD_DATA: begin
              cmd.lk_read = 1'b1;
              state_nxt   = ST_LOOK;
            end
            default: ;
          endcase
        end
      end
      ST_LOOK: begin
        if (stat.lk_drop) begin
          state_nxt = ST_IDLE;
        end else if (stat.out_free) begin
          cmd.lk_emit = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      ST_S2: begin
        cmd.s2_write = 1'b1;
        state_nxt    = ST_IDLE;
      end
      ST_WCMP: begin
        if (!stat.walk_done) begin
          cmd.walk_run = 1'b1;
        end else if (cfg.delete_mode) begin
          cmd.walk_init = 1'b1;
          cmd.kind      = btsd_pkg::WK_DEL;
          state_nxt     = ST_WDEL;
        end else begin
          cmd.end_s1 = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_WDEL: begin
        if (!stat.walk_done) begin
          cmd.walk_run = 1'b1;
        end else begin
          cmd.end_s1 = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_WFILL: begin
        if (!stat.walk_done) begin
          cmd.walk_run = 1'b1;
        end else begin
          cmd.end_s2 = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> src/byte_translate_squeeze_delete_unit.sv
// ---------------------------------------------------------------------------
// byte_translate_squeeze_delete_unit
// Byte translator with delete and run squeeze, table built from set lists.
// A data word is looked up in the code table; unless it is dropped, its result
// is then registered in the output register, waiting while that register holds
// an untaken word. A set2 word passes a read and then a write state. End set1
// and end set2 may start table walks. Sync reset clears modes, counts, flags and
// entry valid bits, so the table reads as identity at once with no clearing pass.
// ---------------------------------------------------------------------------
module byte_translate_squeeze_delete_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  btsd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output btsd_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic                cfg_wdata
);

  btsd_pkg::cfg_t     cfg_r, cfg_nxt;
  btsd_pkg::ctl_cmd_t cmd;
  btsd_pkg::dp_stat_t stat;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        btsd_pkg::CFG_DELETE:  cfg_nxt.delete_mode     = cfg_wdata;
        btsd_pkg::CFG_SQUEEZE: cfg_nxt.squeeze_mode    = cfg_wdata;
        btsd_pkg::CFG_COMPL:   cfg_nxt.complement_mode = cfg_wdata;
        btsd_pkg::CFG_TRUNC:   cfg_nxt.truncate_mode   = cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  btsd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_cmd   (in_data.cmd),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  btsd_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd       (cmd),
    .in_data   (in_data),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> bench/byte_translate_squeeze_delete_unit_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// byte_translate_squeeze_delete_unit_tb
// Self-checking bench for the byte translate/squeeze/delete unit. Commands
// and data words go in over a valid/ready channel. A behavioural copy of
// the code table, source list and modes predicts every emitted byte, and a
// monitor compares each output word with the oldest prediction. Directed
// tests cover identity, pairing, stray commands, delete with squeeze,
// complement with truncate and list overflow. Random sessions then follow
// under several mode settings and handshake idling patterns.
// ---------------------------------------------------------------------------
module byte_translate_squeeze_delete_unit_tb;

  localparam int           SETTLE_CYCLES = btsd_pkg::ALPHABET + btsd_pkg::LIST_DEPTH + 16;
  localparam int           RANDOM_WORDS  = 240;
  localparam int           CHUNK_WORDS   = RANDOM_WORDS / 12;
  localparam longint       TIMEOUT_NS    = 5_000_000;
  localparam logic [2:0]   CMD_SPARE6    = 3'd6;
  localparam logic [2:0]   CMD_SPARE7    = 3'd7;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  btsd_pkg::in_item_t  in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  btsd_pkg::out_item_t out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [1:0]          cfg_index = '0;
  logic                cfg_wdata = 1'b0;

  // predictor state
  btsd_pkg::cfg_t              modes;
  logic [btsd_pkg::CODE_W-1:0] code_tbl [btsd_pkg::ALPHABET];
  logic [7:0]                  src_list [btsd_pkg::LIST_DEPTH];
  int                          src_cnt;
  int                          pair_idx;
  logic [7:0]                  last_s2;
  logic [btsd_pkg::CODE_W-1:0] last_code;
  logic                        last_valid;
  logic                        ovf;
  btsd_pkg::phase_e            ph;

  btsd_pkg::out_item_t pending_bytes [$];
  btsd_pkg::out_item_t want;
  int                  errors     = 0;
  int                  words_sent = 0;
  int                  gap_pct    = 0;
  int                  stall_pct  = 0;

  byte_translate_squeeze_delete_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_bytes.size() == 0) begin
        $error("unexpected word: out_byte %0h list_overflow %0b",
               out_data.out_byte, out_data.list_overflow);
        errors++;
      end else begin
        want = pending_bytes.pop_front();
        if (out_data.out_byte !== want.out_byte) begin
          $error("out_byte: expected %0h, got %0h", want.out_byte, out_data.out_byte);
          errors++;
        end
        if (out_data.list_overflow !== want.list_overflow) begin
          $error("list_overflow: expected %0b, got %0b",
                 want.list_overflow, out_data.list_overflow);
          errors++;
        end
      end
    end
  end

  function automatic void clear_tables();
    for (int n = 0; n < btsd_pkg::ALPHABET; n++) begin
      code_tbl[n] = btsd_pkg::CODE_W'(n & 8'hFF);
    end
    for (int n = 0; n < btsd_pkg::LIST_DEPTH; n++) src_list[n] = '0;
    src_cnt    = 0;
    pair_idx   = 0;
    last_s2    = '0;
    last_code  = '0;
    last_valid = 1'b0;
    ovf        = 1'b0;
    ph         = btsd_pkg::PH_SET1;
  endfunction

  function automatic void translate_word(input btsd_pkg::in_item_t w);
    logic [7:0]                  v;
    logic [7:0]                  c;
    logic [7:0]                  m;
    logic [btsd_pkg::CODE_W-1:0] code;
    logic                        had_s2;
    btsd_pkg::out_item_t         o;
    v = w.value;
    case (w.cmd)
      btsd_pkg::CMD_BEGIN: clear_tables();
      btsd_pkg::CMD_SET1: begin
        if (ph == btsd_pkg::PH_SET1) begin
          code_tbl[v][btsd_pkg::BIT_HIT] = 1'b1;
          if (src_cnt < btsd_pkg::LIST_DEPTH) begin
            src_list[src_cnt] = v;
            src_cnt++;
          end else begin
            ovf = 1'b1;
          end
        end
      end
      btsd_pkg::CMD_END1: begin
        if (ph == btsd_pkg::PH_SET1) begin
          if (modes.complement_mode) begin
            src_cnt = 0;
            for (int n = 0; n < btsd_pkg::ALPHABET; n++) begin
              if (!code_tbl[n][btsd_pkg::BIT_HIT]) begin
                if (src_cnt < btsd_pkg::LIST_DEPTH) begin
                  src_list[src_cnt] = 8'(n);
                  src_cnt++;
                end else begin
                  ovf = 1'b1;
                end
              end
            end
          end
          if (modes.delete_mode) begin
            for (int n = 0; n < src_cnt; n++) begin
              code_tbl[src_list[n]][btsd_pkg::BIT_DEL] = 1'b1;
            end
          end
          pair_idx = 0;
          ph       = btsd_pkg::PH_SET2;
        end
      end
      btsd_pkg::CMD_SET2: begin
        if (ph == btsd_pkg::PH_SET2) begin
          if (modes.delete_mode) begin
            if (modes.squeeze_mode && !code_tbl[v][btsd_pkg::BIT_DEL])
              code_tbl[v] = {1'b1, 2'b00, v};
          end else begin
            last_s2 = v;
            if (pair_idx < src_cnt) begin
              code_tbl[src_list[pair_idx]] = {modes.squeeze_mode, 2'b00, v};
              pair_idx++;
            end
          end
        end
      end
      btsd_pkg::CMD_END2: begin
        if (ph == btsd_pkg::PH_SET2) begin
          if (!modes.delete_mode) begin
            had_s2 = (pair_idx > 0);
            for (int i = pair_idx; i < src_cnt; i++) begin
              c = src_list[i];
              if (had_s2) m = modes.truncate_mode ? c : last_s2;
              else        m = modes.squeeze_mode ? c : 8'h00;
              code_tbl[c] = {modes.squeeze_mode, 2'b00, m};
            end
            pair_idx = src_cnt;
          end
          ph = btsd_pkg::PH_DATA;
        end
      end
      btsd_pkg::CMD_DATA: begin
        code = code_tbl[v];
        if (!code[btsd_pkg::BIT_DEL] && !(last_valid && code == last_code)) begin
          o.out_byte      = code[7:0];
          o.list_overflow = ovf;
          pending_bytes.push_back(o);
          last_code                   = code;
          last_code[btsd_pkg::BIT_SQZ] = 1'b1;
          last_valid                  = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_word(input logic [2:0] cmd, input logic [7:0] value);
    btsd_pkg::in_item_t w;
    w.cmd   = cmd;
    w.value = value;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    translate_word(w);
    words_sent++;
  endtask

  // hold input off until every byte is back and any table walk has finished
  task automatic quiesce();
    in_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_word(input btsd_pkg::cfg_idx_e idx, input logic val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_modes(input btsd_pkg::cfg_t m);
    quiesce();
    cfg_word(btsd_pkg::CFG_DELETE,  m.delete_mode);
    cfg_word(btsd_pkg::CFG_SQUEEZE, m.squeeze_mode);
    cfg_word(btsd_pkg::CFG_COMPL,   m.complement_mode);
    cfg_word(btsd_pkg::CFG_TRUNC,   m.truncate_mode);
    cfg_valid <= 1'b0;
    modes = m;
  endtask

  task automatic test_identity_and_order();
    set_modes('0);
    send_word(btsd_pkg::CMD_BEGIN, 8'hFF);
    send_word(btsd_pkg::CMD_DATA, 8'h00);
    send_word(btsd_pkg::CMD_DATA, 8'hFF);
    send_word(btsd_pkg::CMD_SET1, 8'h61);
    send_word(btsd_pkg::CMD_SET1, 8'h62);
    send_word(btsd_pkg::CMD_SET1, 8'h61);
    send_word(btsd_pkg::CMD_END1, 8'h00);
    send_word(btsd_pkg::CMD_SET1, 8'h63);
    send_word(btsd_pkg::CMD_SET2, 8'h78);
    send_word(btsd_pkg::CMD_END2, 8'h00);
    send_word(btsd_pkg::CMD_SET2, 8'h79);
    send_word(btsd_pkg::CMD_END1, 8'h00);
    send_word(btsd_pkg::CMD_DATA, 8'h61);
    send_word(btsd_pkg::CMD_DATA, 8'h62);
    send_word(btsd_pkg::CMD_DATA, 8'h63);
    send_word(CMD_SPARE6, 8'h55);
    send_word(CMD_SPARE7, 8'hAA);
    send_word(btsd_pkg::CMD_DATA, 8'h63);
  endtask

  task automatic test_delete_squeeze();
    set_modes('{delete_mode: 1'b1, squeeze_mode: 1'b1,
                complement_mode: 1'b0, truncate_mode: 1'b0});
    send_word(btsd_pkg::CMD_BEGIN, 8'h00);
    send_word(btsd_pkg::CMD_SET1, 8'h30);
    send_word(btsd_pkg::CMD_END1, 8'h00);
    send_word(btsd_pkg::CMD_SET2, 8'h41);
    send_word(btsd_pkg::CMD_SET2, 8'h30);
    send_word(btsd_pkg::CMD_END2, 8'h00);
    send_word(btsd_pkg::CMD_DATA, 8'h30);
    send_word(btsd_pkg::CMD_DATA, 8'h41);
    send_word(btsd_pkg::CMD_DATA, 8'h41);
    send_word(btsd_pkg::CMD_DATA, 8'h42);
    send_word(btsd_pkg::CMD_DATA, 8'h42);
  endtask

  task automatic test_complement_truncate();
    set_modes('{delete_mode: 1'b0, squeeze_mode: 1'b1,
                complement_mode: 1'b1, truncate_mode: 1'b1});
    send_word(btsd_pkg::CMD_BEGIN, 8'h00);
    send_word(btsd_pkg::CMD_SET1, 8'h41);
    send_word(btsd_pkg::CMD_END1, 8'h00);
    send_word(btsd_pkg::CMD_SET2, 8'h5A);
    send_word(btsd_pkg::CMD_END2, 8'h00);
    send_word(btsd_pkg::CMD_DATA, 8'h00);
    send_word(btsd_pkg::CMD_DATA, 8'h01);
    send_word(btsd_pkg::CMD_DATA, 8'h01);
    send_word(btsd_pkg::CMD_DATA, 8'h41);
    send_word(btsd_pkg::CMD_DATA, 8'h41);
    // empty set2: unpaired entries keep their own value
    send_word(btsd_pkg::CMD_BEGIN, 8'h00);
    send_word(btsd_pkg::CMD_SET1, 8'h10);
    send_word(btsd_pkg::CMD_END1, 8'h00);
    send_word(btsd_pkg::CMD_END2, 8'h00);
    send_word(btsd_pkg::CMD_DATA, 8'h20);
    send_word(btsd_pkg::CMD_DATA, 8'h20);
    send_word(btsd_pkg::CMD_DATA, 8'h10);
  endtask

  task automatic test_list_overflow();
    set_modes('0);
    send_word(btsd_pkg::CMD_BEGIN, 8'h00);
    repeat (btsd_pkg::LIST_DEPTH + 3) send_word(btsd_pkg::CMD_SET1, 8'($urandom));
    send_word(btsd_pkg::CMD_END1, 8'h00);
    send_word(btsd_pkg::CMD_SET2, 8'h2A);
    send_word(btsd_pkg::CMD_END2, 8'h00);
    repeat (4) send_word(btsd_pkg::CMD_DATA, 8'($urandom));
    send_word(btsd_pkg::CMD_BEGIN, 8'h00);
    send_word(btsd_pkg::CMD_DATA, 8'h7F);
  endtask

  function automatic logic [7:0] pick_byte(input logic [7:0] base);
    if ($urandom_range(0, 9) < 7) return base + 8'($urandom_range(0, 7));
    return 8'($urandom);
  endfunction

  task automatic maybe_noise();
    if ($urandom_range(0, 99) < 8) send_word(3'($urandom_range(0, 7)), 8'($urandom));
  endtask

  task automatic random_session();
    logic [7:0] base;
    logic [7:0] prev;
    base = 8'($urandom);
    prev = base;
    if ($urandom_range(0, 9) != 0) send_word(btsd_pkg::CMD_BEGIN, 8'($urandom));
    repeat ($urandom_range(0, 8)) begin
      send_word(btsd_pkg::CMD_SET1, pick_byte(base));
      maybe_noise();
    end
    send_word(btsd_pkg::CMD_END1, 8'($urandom));
    repeat ($urandom_range(0, 10)) begin
      send_word(btsd_pkg::CMD_SET2, pick_byte(base));
      maybe_noise();
    end
    send_word(btsd_pkg::CMD_END2, 8'($urandom));
    repeat ($urandom_range(3, 16)) begin
      if ($urandom_range(0, 9) >= 4) prev = pick_byte(base);
      send_word(btsd_pkg::CMD_DATA, prev);
      maybe_noise();
    end
  endtask

  task automatic test_random_sessions();
    int             goal;
    btsd_pkg::cfg_t m;
    goal = words_sent;
    for (int p = 0; p < 4; p++) begin
      for (int k = 0; k < 3; k++) begin
        if (p == 0 && k == 0)      m = '0;
        else if (p == 3 && k == 2) m = '1;
        else                       m = btsd_pkg::cfg_t'(4'($urandom_range(0, 15)));
        set_modes(m);
        case (p)
          0: begin gap_pct = 0;  stall_pct = 0;  end
          1: begin gap_pct = 57; stall_pct = 0;  end
          2: begin gap_pct = 0;  stall_pct = 57; end
          default: begin gap_pct = 26; stall_pct = 26; end
        endcase
        goal = goal + CHUNK_WORDS;
        while (words_sent < goal) random_session();
      end
    end
  endtask

  initial begin
    modes = '0;
    clear_tables();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_identity_and_order();
    test_delete_squeeze();
    test_complement_truncate();
    test_list_overflow();
    test_random_sessions();
    quiesce();
    if (errors == 0) begin
      $display("byte_translate_squeeze_delete_unit test passed");
    end else begin
      $display("byte_translate_squeeze_delete_unit test failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("byte_translate_squeeze_delete_unit test failed");
    $finish;
  end

endmodule
